// ===== hdl/lrf_pkg.sv =====
// Package for the log record framer: command codes, frame marks and the job word.
// Used by every module of the framer; depends on nothing.
package lrf_pkg;

    // Command codes of the input word.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Frame marks.
    localparam logic [7:0] MARK_START  = 8'hEB;
    localparam logic [7:0] MARK_ESCAPE = 8'hEC;
    localparam logic [7:0] MARK_END    = 8'hEE;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One job holds every output word caused by one input word.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } job_t;

    // Escape lookup result.
    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } esc_t;

    // Status of the back end.
    typedef struct packed {
        logic active;
    } back_status_t;

    // Maps a reserved byte to its escape code.
    function automatic esc_t escape_lookup(input logic [7:0] b);
        esc_t e;
        e.hit = 1'b1;
        case (b)
            8'hEB:   e.code = 8'd0;
            8'hEC:   e.code = 8'd1;
            8'hEE:   e.code = 8'd2;
            8'hED:   e.code = 8'd3;
            8'h11:   e.code = 8'd4;
            8'h13:   e.code = 8'd5;
            default:
            begin
                e.hit  = 1'b0;
                e.code = 8'd0;
            end
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/lrf_front.sv =====
// Front end of the framer: keeps the running sum and turns each command into a job.
// Depends on lrf_pkg.
module lrf_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  command,
    input  logic [7:0]  value,
    output logic        push,
    output lrf_pkg::job_t job
);
    import lrf_pkg::*;

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    esc_t       esc_value;
    esc_t       esc_sum;

    assign esc_value = escape_lookup(value);
    assign esc_sum   = escape_lookup(sum_reg);

    // Build the job; an unused command pushes nothing.
    always_comb
    begin
        sum_next  = sum_reg;
        push      = 1'b0;
        job.count = 2'd1;
        job.bytes = '0;
        unique case (command)
            CMD_START:
            begin
                push         = accept;
                job.count    = 2'd2;
                job.bytes[0] = MARK_START;
                job.bytes[1] = value;
                sum_next     = value;
            end
            CMD_DATA:
            begin
                push     = accept;
                sum_next = sum_reg + value;
                if (esc_value.hit)
                begin
                    job.count    = 2'd2;
                    job.bytes[0] = MARK_ESCAPE;
                    job.bytes[1] = esc_value.code;
                end
                else
                begin
                    job.count    = 2'd1;
                    job.bytes[0] = value;
                end
            end
            CMD_END:
            begin
                push         = accept;
                job.bytes[0] = MARK_END;
                if (esc_sum.hit)
                begin
                    job.count    = 2'd3;
                    job.bytes[1] = MARK_ESCAPE;
                    job.bytes[2] = esc_sum.code;
                end
                else
                begin
                    job.count    = 2'd2;
                    job.bytes[1] = sum_reg;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Running checksum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (accept)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== hdl/lrf_queue.sv =====
// Short job queue between the front and the back of the framer.
// Depends on lrf_pkg.
module lrf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lrf_pkg::job_t push_job,
    input  logic          pop,
    output lrf_pkg::job_t head_job,
    output logic          head_valid,
    output logic          full
);
    import lrf_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_job   = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lrf_back.sv =====
// Back end of the framer: serializes queued jobs into output words.
// Depends on lrf_pkg.
module lrf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrf_pkg::job_t        head_job,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 last,
    output lrf_pkg::back_status_t status
);
    import lrf_pkg::*;

    job_t       cur_reg;
    job_t       cur_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       active_reg;
    logic       active_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       load;

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign last          = last_reg;
    assign status.active = active_reg;

    // Pick the next word: rest of the current job first, then the queue head.
    always_comb
    begin
        load        = (!valid_reg || out_ready) && (active_reg || head_valid);
        pop         = 1'b0;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            if (active_reg)
            begin
                byte_next = cur_reg.bytes[idx_reg];
                last_next = (idx_reg == cur_reg.count - 2'd1);
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == cur_reg.count - 2'd1)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                pop       = 1'b1;
                byte_next = head_job.bytes[0];
                last_next = (head_job.count == 2'd1);
                cur_next  = head_job;
                idx_next  = 2'd1;
                active_next = (head_job.count != 2'd1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ===== hdl/log_record_framer_escape_checksum_core.sv =====
// Top level of the log record framer with byte stuffing and additive checksum.
// Depends on lrf_pkg, lrf_front, lrf_queue and lrf_back.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     command[1:0], value[7:0]
//   output   out_valid / out_ready   out_byte[7:0], last
//
// Each command other than CMD_NONE yields one to three output words, one per cycle
// while out_ready is high, so the output port sets the rate.
// The front accepts a command in any cycle in which the two-entry job queue
// has room; its first word passes through the queue and then the output register.
// Reset clears the running sum, the queue and the output register.
// Output stalls back up through the queue to in_ready without losing words.
module log_record_framer_escape_checksum_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);
    import lrf_pkg::*;

    logic         accept;
    logic         push;
    job_t         push_job;
    job_t         head_job;
    logic         head_valid;
    logic         q_full;
    logic         pop;
    back_status_t back_status;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    lrf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .value   (value),
        .push    (push),
        .job     (push_job)
    );

    lrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (q_full)
    );

    lrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last),
        .status     (back_status)
    );

    // The back never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty job queue");

    // The front never pushes into a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full job queue");

    // A job in progress always has its previous word on the output.
    a_active_valid: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.active |-> out_valid)
        else $error("job in progress without a pending output word");

    // A pending job word is not marked last.
    a_active_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.active |-> !last)
        else $error("last marked before the job is complete");

endmodule
